[rtl/nsc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared types, character codes and helper functions of the numeric string
// classifier.
// ----------------------------------------------------------------------------
package nsc_pkg;

    localparam int EXP_W = 16;
    localparam logic [EXP_W-1:0] EXP_MAX = '1;

    localparam logic [5:0] RADIX_MIN = 6'd2;
    localparam logic [5:0] RADIX_MAX = 6'd36;
    localparam logic [5:0] RADIX_DEC = 6'd10;
    localparam logic [5:0] RADIX_HEX = 6'd16;
    localparam logic [5:0] RADIX_OCT = 6'd8;
    localparam logic [5:0] RADIX_BIN = 6'd2;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_E_LO  = 8'h65;
    localparam logic [7:0] CH_E_UP  = 8'h45;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_Z_LO  = 8'h7A;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_Z_UP  = 8'h5A;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_O_LO  = 8'h6F;
    localparam logic [7:0] CH_O_UP  = 8'h4F;
    localparam logic [7:0] CH_B_LO  = 8'h62;
    localparam logic [7:0] CH_B_UP  = 8'h42;

    localparam logic [6:0] DIGIT_NONE = 7'd99;

    // result classes
    localparam logic [1:0] CLS_INVALID  = 2'd0;
    localparam logic [1:0] CLS_INTEGER  = 2'd1;
    localparam logic [1:0] CLS_FLOAT    = 2'd2;
    localparam logic [1:0] CLS_INTEGRAL = 2'd3;

    typedef enum logic [4:0] {
        PH_INT      = 5'b00001,
        PH_DEC      = 5'b00010,
        PH_EXP_SIGN = 5'b00100,
        PH_EXP_DIG  = 5'b01000,
        PH_BAD      = 5'b10000
    } phase_t;

    // parse flags and exponent of the string in progress
    typedef struct packed {
        phase_t           phase;
        logic             first_was_zero;
        logic             int_digit_seen;
        logic             dot_seen;
        logic             exp_negative;
        logic             exp_digit_seen;
        logic [EXP_W-1:0] exp_value;
    } parse_t;

    localparam parse_t PARSE_CLEAR = '{
        phase:          PH_INT,
        first_was_zero: 1'b0,
        int_digit_seen: 1'b0,
        dot_seen:       1'b0,
        exp_negative:   1'b0,
        exp_digit_seen: 1'b0,
        exp_value:      '0
    };

    // digit value in any radix up to 36, DIGIT_NONE for anything else
    function automatic logic [6:0] digit_value(input logic [7:0] c);
        logic [6:0] v;
        begin
            if (c inside {[CH_ZERO:CH_NINE]})
                v = {3'd0, c[3:0]};
            else if (c inside {[CH_A_LO:CH_Z_LO]})
                v = 7'(c - CH_A_LO + 8'd10);
            else if (c inside {[CH_A_UP:CH_Z_UP]})
                v = 7'(c - CH_A_UP + 8'd10);
            else
                v = DIGIT_NONE;
            return v;
        end
    endfunction

    function automatic logic is_prefix_letter(input logic [7:0] c, input logic [5:0] r);
        begin
            return ((r == RADIX_HEX) && (c == CH_X_LO || c == CH_X_UP)) ||
                   ((r == RADIX_OCT) && (c == CH_O_LO || c == CH_O_UP)) ||
                   ((r == RADIX_BIN) && (c == CH_B_LO || c == CH_B_UP));
        end
    endfunction

endpackage
`default_nettype wire

[rtl/nsc_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_step
// Next-state logic: folds one character into the parse state of the string.
// ----------------------------------------------------------------------------
module nsc_step
    import nsc_pkg::*;
#(
    parameter int MAX_LEN = 255,
    parameter int LEN_W   = $clog2(MAX_LEN + 1)
)
(
    input  wire logic [5:0]       radix,
    input  wire logic [7:0]       char_code,
    input  wire logic             no_char,
    input  wire parse_t           cur,
    input  wire logic [LEN_W-1:0] char_index,
    input  wire logic [LEN_W-1:0] int_tz,
    input  wire logic [LEN_W-1:0] dec_count,
    input  wire logic [LEN_W-1:0] dec_tz,
    output parse_t                nxt,
    output logic [LEN_W-1:0]      char_index_nxt,
    output logic [LEN_W-1:0]      int_tz_nxt,
    output logic [LEN_W-1:0]      dec_count_nxt,
    output logic [LEN_W-1:0]      dec_tz_nxt
);

    localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN);
    localparam logic [LEN_W-1:0] ONE       = LEN_W'(1);

    logic              is_dig;
    logic              is_zero;
    logic              is_e;
    logic [EXP_W+3:0]  exp_mul;

    assign is_dig  = (char_code inside {[CH_ZERO:CH_NINE]});
    assign is_zero = (char_code == CH_ZERO);
    assign is_e    = (char_code == CH_E_LO) || (char_code == CH_E_UP);

    // exponent times ten plus the new digit
    assign exp_mul = ({4'd0, cur.exp_value} << 3) + ({4'd0, cur.exp_value} << 1)
                   + {{EXP_W{1'b0}}, char_code[3:0]};

    always_comb
    begin
        nxt            = cur;
        char_index_nxt = char_index;
        int_tz_nxt     = int_tz;
        dec_count_nxt  = dec_count;
        dec_tz_nxt     = dec_tz;

        if (!no_char) begin
            if (char_index >= LEN_LIMIT) begin
                nxt.phase = PH_BAD;
            end else begin
                char_index_nxt = char_index + ONE;
                if (radix != RADIX_DEC) begin
                    // based number: optional 0x / 0o / 0b then digits
                    if (cur.phase == PH_INT) begin
                        if (char_index == ONE && cur.first_was_zero &&
                            is_prefix_letter(char_code, radix)) begin
                            nxt.int_digit_seen = 1'b0;
                        end else if (digit_value(char_code) < {1'b0, radix}) begin
                            if (char_index == '0 && is_zero)
                                nxt.first_was_zero = 1'b1;
                            nxt.int_digit_seen = 1'b1;
                        end else begin
                            nxt.phase = PH_BAD;
                        end
                    end
                end else begin
                    case (cur.phase)
                        PH_INT:
                        begin
                            if (is_dig) begin
                                nxt.int_digit_seen = 1'b1;
                                int_tz_nxt = is_zero ? int_tz + ONE : '0;
                            end else if (char_code == CH_DOT) begin
                                nxt.dot_seen = 1'b1;
                                nxt.phase    = PH_DEC;
                            end else if (is_e && cur.int_digit_seen) begin
                                nxt.phase = PH_EXP_SIGN;
                            end else begin
                                nxt.phase = PH_BAD;
                            end
                        end
                        PH_DEC:
                        begin
                            if (is_dig) begin
                                dec_count_nxt = dec_count + ONE;
                                dec_tz_nxt    = is_zero ? dec_tz + ONE : '0;
                            end else if (is_e && (cur.int_digit_seen || dec_count != '0)) begin
                                nxt.phase = PH_EXP_SIGN;
                            end else begin
                                nxt.phase = PH_BAD;
                            end
                        end
                        PH_EXP_SIGN, PH_EXP_DIG:
                        begin
                            if (is_dig) begin
                                nxt.exp_value = (exp_mul > {4'd0, EXP_MAX})
                                              ? EXP_MAX : exp_mul[EXP_W-1:0];
                                nxt.exp_digit_seen = 1'b1;
                                nxt.phase = PH_EXP_DIG;
                            end else if (cur.phase == PH_EXP_SIGN &&
                                         (char_code == CH_PLUS || char_code == CH_MINUS)) begin
                                nxt.exp_negative = (char_code == CH_MINUS);
                                nxt.phase = PH_EXP_DIG;
                            end else begin
                                nxt.phase = PH_BAD;
                            end
                        end
                        default:
                        begin
                            nxt.phase = PH_BAD;
                        end
                    endcase
                end
            end
        end
    end

endmodule
`default_nettype wire

[rtl/nsc_verdict.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// nsc_verdict
// Class of a finished string from its final parse state.
// ----------------------------------------------------------------------------
module nsc_verdict
    import nsc_pkg::*;
#(
    parameter int LEN_W = 8
)
(
    input  wire logic [5:0]       radix,
    input  wire parse_t           st,
    input  wire logic [LEN_W-1:0] char_index,
    input  wire logic [LEN_W-1:0] int_tz,
    input  wire logic [LEN_W-1:0] dec_count,
    input  wire logic [LEN_W-1:0] dec_tz,
    output logic [1:0]            num_class
);

    localparam int CMP_W = (LEN_W > EXP_W) ? LEN_W : EXP_W;

    logic [LEN_W-1:0] kept;
    logic [CMP_W-1:0] exp_c;
    logic [CMP_W-1:0] int_tz_c;
    logic [CMP_W-1:0] kept_c;
    logic             has_exp;

    // decimal digits that are not trailing zeros
    assign kept     = dec_count - dec_tz;
    assign exp_c    = CMP_W'(st.exp_value);
    assign int_tz_c = CMP_W'(int_tz);
    assign kept_c   = CMP_W'(kept);
    assign has_exp  = (st.phase == PH_EXP_SIGN) || (st.phase == PH_EXP_DIG);

    always_comb
    begin
        if (radix < RADIX_MIN || radix > RADIX_MAX || char_index == '0 ||
            st.phase == PH_BAD) begin
            num_class = CLS_INVALID;
        end else if (radix != RADIX_DEC) begin
            num_class = (st.phase == PH_INT && st.int_digit_seen) ? CLS_INTEGER : CLS_INVALID;
        end else if (!st.int_digit_seen && dec_count == '0) begin
            num_class = CLS_INVALID;
        end else if (has_exp && !st.exp_digit_seen) begin
            num_class = CLS_INVALID;
        end else if (!st.dot_seen && !has_exp) begin
            num_class = CLS_INTEGER;
        end else if (st.exp_negative) begin
            num_class = (exp_c <= int_tz_c && kept == '0) ? CLS_INTEGRAL : CLS_FLOAT;
        end else begin
            num_class = (exp_c >= kept_c) ? CLS_INTEGRAL : CLS_FLOAT;
        end
    end

endmodule
`default_nettype wire

[rtl/numeric_string_classifier.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// numeric_string_classifier
// Classifies a streamed numeric string as invalid, integer, float or float
// with an integral value.
// ----------------------------------------------------------------------------
// usage
//   input channel: one character per beat (char_code), no_char marks a beat
//   that carries no character (an empty string is a single such beat), last
//   closes the string. output channel: one num_class beat per string, sent
//   for the beat that carries last
//   radix is written through radix_we / radix_wdata while the block is idle
//   (resets to ten; ten enables the dot and exponent syntax)
//   result path: the input register, then the result register
//   throughput: one input beat per cycle unless in_stall is high; the step and
//   verdict logic between the input and result registers is combinational
//   reset: all string state clears, radix returns to ten, both valids drop
//   stall: a stalled result holds; input beats without last keep flowing
//   past it, and a further last beat waits in the input register, which
//   then raises in_stall
// ----------------------------------------------------------------------------
module numeric_string_classifier
    import nsc_pkg::*;
#(
    parameter int MAX_LEN = 255
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,

    input  wire logic       radix_we,
    input  wire logic [5:0] radix_wdata,

    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_code,
    input  wire logic       no_char,
    input  wire logic       last,

    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [1:0]      num_class
);

    localparam int LEN_W = $clog2(MAX_LEN + 1);

    // configuration
    logic [5:0]       radix_reg;

    // input register
    logic             s1_valid_reg, s1_valid_next;
    logic [7:0]       s1_char_reg;
    logic             s1_none_reg;
    logic             s1_last_reg;

    // string parse state
    parse_t           parse_reg, parse_next;
    logic [LEN_W-1:0] char_index_reg, char_index_next;
    logic [LEN_W-1:0] int_tz_reg, int_tz_next;
    logic [LEN_W-1:0] dec_count_reg, dec_count_next;
    logic [LEN_W-1:0] dec_tz_reg, dec_tz_next;

    // result register
    logic             out_valid_reg, out_valid_next;
    logic [1:0]       num_class_reg;

    logic             in_accept;
    logic             advance;
    logic [1:0]       class_now;

    // a beat leaves the input register unless it needs the result register
    // and that register is still held by the receiver
    assign advance   = s1_valid_reg && (!s1_last_reg || !out_valid_reg || !out_stall);
    assign in_stall  = s1_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    nsc_step #(
        .MAX_LEN (MAX_LEN),
        .LEN_W   (LEN_W)
    ) u_step (
        .radix          (radix_reg),
        .char_code      (s1_char_reg),
        .no_char        (s1_none_reg),
        .cur            (parse_reg),
        .char_index     (char_index_reg),
        .int_tz         (int_tz_reg),
        .dec_count      (dec_count_reg),
        .dec_tz         (dec_tz_reg),
        .nxt            (parse_next),
        .char_index_nxt (char_index_next),
        .int_tz_nxt     (int_tz_next),
        .dec_count_nxt  (dec_count_next),
        .dec_tz_nxt     (dec_tz_next)
    );

    // verdict is taken on the state that includes the last character
    nsc_verdict #(
        .LEN_W (LEN_W)
    ) u_verdict (
        .radix      (radix_reg),
        .st         (parse_next),
        .char_index (char_index_next),
        .int_tz     (int_tz_next),
        .dec_count  (dec_count_next),
        .dec_tz     (dec_tz_next),
        .num_class  (class_now)
    );

    assign s1_valid_next = in_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

    always_comb
    begin
        if (advance && s1_last_reg)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            radix_reg      <= RADIX_DEC;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            parse_reg      <= PARSE_CLEAR;
            char_index_reg <= '0;
            int_tz_reg     <= '0;
            dec_count_reg  <= '0;
            dec_tz_reg     <= '0;
        end else begin
            if (radix_we)
                radix_reg <= radix_wdata;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                // a finished string leaves a clean slate for the next one
                if (s1_last_reg) begin
                    parse_reg      <= PARSE_CLEAR;
                    char_index_reg <= '0;
                    int_tz_reg     <= '0;
                    dec_count_reg  <= '0;
                    dec_tz_reg     <= '0;
                end else begin
                    parse_reg      <= parse_next;
                    char_index_reg <= char_index_next;
                    int_tz_reg     <= int_tz_next;
                    dec_count_reg  <= dec_count_next;
                    dec_tz_reg     <= dec_tz_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_char_reg <= char_code;
            s1_none_reg <= no_char;
            s1_last_reg <= last;
        end
        if (advance && s1_last_reg)
            num_class_reg <= class_now;
    end

    assign out_valid = out_valid_reg;
    assign num_class = num_class_reg;

endmodule
`default_nettype wire

[test/numeric_string_classifier_test.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// numeric_string_classifier_test
// Self-checking bench for the numeric string classifier. A short table of
// hand-picked strings is followed by random phases, each under its own radix.
// Every accepted input beat steps a local copy of the parser, and every
// num_class beat is compared with the oldest class still due.
// ----------------------------------------------------------------------------
module numeric_string_classifier_test;
    import nsc_pkg::*;

    localparam int MAX_CHARS       = 255;
    localparam int PREDICT         = -1;   // row class comes from the local parser
    localparam int SETTLE_CYCLES   = 4;    // input register plus parse stage, with margin
    localparam int WATCHDOG_CYCLES = 2000;
    localparam int NUM_ROWS        = 27;
    localparam int NUM_PHASES      = 14;

    // one input beat
    typedef struct packed {
        logic [7:0] code;
        logic       none;
        logic       fin;
    } beat_t;

    // one row of the directed table: text, then reps copies of fill
    typedef struct {
        int         radix;
        string      text;
        logic [7:0] fill;
        int         reps;
        int         hole;   // a no-character beat goes in before this position, -1 for none
        int         cls;
    } dir_row_t;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       radix_we    = 1'b0;
    logic [5:0] radix_wdata = 6'd0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [7:0] char_code   = 8'h00;
    logic       no_char     = 1'b0;
    logic       last        = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    logic [1:0] num_class;

    // classes still owed by the block, oldest first
    logic [1:0] due_classes[$];
    // beats of the string being built for sending
    beat_t      text_q[$];

    int         errors       = 0;
    int         quiet_cycles = 0;
    int         stall_left   = 0;
    logic       no_idle      = 1'b0;

    dir_row_t   rows [NUM_ROWS];

    // local copy of the parser state
    logic [5:0] radix_now;
    phase_t     st_phase;
    logic [7:0] chars_taken;
    logic       lead_zero;
    logic       int_seen;
    logic [7:0] int_tz;
    logic       dot;
    logic [7:0] frac_len;
    logic [7:0] frac_tz;
    logic [15:0] expo;
    logic       expo_neg;
    logic       expo_seen;

    numeric_string_classifier #(
        .MAX_LEN(MAX_CHARS)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .radix_we   (radix_we),
        .radix_wdata(radix_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .no_char    (no_char),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .num_class  (num_class)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------------

    // fresh string, radix kept
    function automatic void clear_string_state();
        st_phase    = PH_INT;
        chars_taken = 8'd0;
        lead_zero   = 1'b0;
        int_seen    = 1'b0;
        int_tz      = 8'd0;
        dot         = 1'b0;
        frac_len    = 8'd0;
        frac_tz     = 8'd0;
        expo        = 16'd0;
        expo_neg    = 1'b0;
        expo_seen   = 1'b0;
    endfunction

    // value of a digit in radix up to 36, 99 for anything that is no digit
    function automatic int digit_of(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE)
            return int'(c) - int'(CH_ZERO);
        if (c >= CH_A_LO && c <= CH_Z_LO)
            return int'(c) - int'(CH_A_LO) + 10;
        if (c >= CH_A_UP && c <= CH_Z_UP)
            return int'(c) - int'(CH_A_UP) + 10;
        return 99;
    endfunction

    // folding to lower case is safe here: only x, o and b are ever matched
    function automatic logic prefix_letter(input logic [7:0] c, input logic [5:0] r);
        logic [7:0] lc;
        lc = c | 8'h20;
        case (r)
            RADIX_HEX: return lc == CH_X_LO;
            RADIX_OCT: return lc == CH_O_LO;
            RADIX_BIN: return lc == CH_B_LO;
            default:   return 1'b0;
        endcase
    endfunction

    // any radix other than ten: optional prefix, then radix digits
    function automatic void take_based(input logic [7:0] c);
        if (st_phase != PH_INT)
            return;
        if (chars_taken == 8'd1 && lead_zero && prefix_letter(c, radix_now))
        begin
            int_seen = 1'b0;
            return;
        end
        if (digit_of(c) < int'(radix_now))
        begin
            if (chars_taken == 8'd0 && c == CH_ZERO)
                lead_zero = 1'b1;
            int_seen = 1'b1;
        end
        else
            st_phase = PH_BAD;
    endfunction

    // radix ten: integer digits, dot and decimals, exponent with sign
    function automatic void take_decimal(input logic [7:0] c);
        logic is_dig;
        logic is_e;
        int   v;
        is_dig = (c >= CH_ZERO && c <= CH_NINE);
        is_e   = (c == CH_E_LO || c == CH_E_UP);
        case (st_phase)
            PH_INT:
            begin
                if (is_dig)
                begin
                    int_seen = 1'b1;
                    int_tz   = (c == CH_ZERO) ? int_tz + 8'd1 : 8'd0;
                end
                else if (c == CH_DOT)
                begin
                    dot      = 1'b1;
                    st_phase = PH_DEC;
                end
                else if (is_e && int_seen)
                    st_phase = PH_EXP_SIGN;
                else
                    st_phase = PH_BAD;
            end
            PH_DEC:
            begin
                if (is_dig)
                begin
                    frac_len = frac_len + 8'd1;
                    frac_tz  = (c == CH_ZERO) ? frac_tz + 8'd1 : 8'd0;
                end
                else if (is_e && (int_seen || frac_len != 8'd0))
                    st_phase = PH_EXP_SIGN;
                else
                    st_phase = PH_BAD;
            end
            PH_EXP_SIGN, PH_EXP_DIG:
            begin
                if (is_dig)
                begin
                    // exponent sticks at its ceiling rather than wrapping
                    v         = int'(expo) * 10 + (int'(c) - int'(CH_ZERO));
                    expo      = (v > int'(EXP_MAX)) ? EXP_MAX : 16'(v);
                    expo_seen = 1'b1;
                    st_phase  = PH_EXP_DIG;
                end
                else if (st_phase == PH_EXP_SIGN && (c == CH_PLUS || c == CH_MINUS))
                begin
                    expo_neg = (c == CH_MINUS);
                    st_phase = PH_EXP_DIG;
                end
                else
                    st_phase = PH_BAD;
            end
            default:
                st_phase = PH_BAD;
        endcase
    endfunction

    // class of the string taken so far
    function automatic logic [1:0] string_class();
        logic has_exp;
        int   kept;
        if (radix_now < RADIX_MIN || radix_now > RADIX_MAX || chars_taken == 8'd0 ||
            st_phase == PH_BAD)
            return CLS_INVALID;
        if (radix_now != RADIX_DEC)
            return (st_phase == PH_INT && int_seen) ? CLS_INTEGER : CLS_INVALID;
        if (!int_seen && frac_len == 8'd0)
            return CLS_INVALID;
        has_exp = (st_phase == PH_EXP_SIGN || st_phase == PH_EXP_DIG);
        if (has_exp && !expo_seen)
            return CLS_INVALID;
        if (!dot && !has_exp)
            return CLS_INTEGER;
        // decimals that survive once the trailing zeros are dropped
        kept = int'(frac_len) - int'(frac_tz);
        if (expo_neg)
        begin
            if (int'(expo) <= int'(int_tz) && kept == 0)
                return CLS_INTEGRAL;
        end
        else if (int'(expo) >= kept)
            return CLS_INTEGRAL;
        return CLS_FLOAT;
    endfunction

    // one accepted beat through the model; a last beat yields a class
    task automatic step_parser(input beat_t b, output logic has_cls, output logic [1:0] cls);
        has_cls = 1'b0;
        cls     = CLS_INVALID;
        if (!b.none)
        begin
            if (int'(chars_taken) >= MAX_CHARS)
                st_phase = PH_BAD;
            else
            begin
                if (radix_now == RADIX_DEC)
                    take_decimal(b.code);
                else
                    take_based(b.code);
                chars_taken = chars_taken + 8'd1;
            end
        end
        if (b.fin)
        begin
            has_cls = 1'b1;
            cls     = string_class();
            clear_string_state();
        end
    endtask

    // ------------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------------

    function automatic beat_t beat(input logic [7:0] c, input logic none, input logic fin);
        beat_t b;
        b.code = c;
        b.none = none;
        b.fin  = fin;
        return b;
    endfunction

    // offer one beat, hold it through any stall, then step the model;
    // valid stays high between back-to-back beats
    task automatic send_beat(input beat_t b, input int forced);
        logic       got;
        logic [1:0] cls;
        if (!no_idle && $urandom_range(0, 99) < 3)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= b.code;
        no_char   <= b.none;
        last      <= b.fin;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        step_parser(b, got, cls);
        if (got)
            due_classes.push_back((forced == PREDICT) ? cls : 2'(forced));
    endtask

    // radix only changes with the block drained and the parse stage settled
    task automatic set_radix(input logic [5:0] v);
        in_valid <= 1'b0;
        while (due_classes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        radix_we    <= 1'b1;
        radix_wdata <= v;
        @(posedge clk);
        radix_we  <= 1'b0;
        radix_now = v;
    endtask

    // ------------------------------------------------------------------------
    // random strings
    // ------------------------------------------------------------------------

    function automatic void put(input logic [7:0] c);
        text_q.push_back(beat(c, 1'b0, 1'b0));
    endfunction

    // zeros are weighted up so that trailing-zero counts get exercised
    function automatic logic [7:0] dec_digit();
        if ($urandom_range(0, 99) < 40)
            return CH_ZERO;
        return CH_ZERO + 8'($urandom_range(1, 9));
    endfunction

    function automatic logic [7:0] based_digit(input int r);
        int v;
        v = $urandom_range(0, r - 1);
        if (v < 10)
            return CH_ZERO + 8'(v);
        return ($urandom_range(0, 1) ? CH_A_UP : CH_A_LO) + 8'(v - 10);
    endfunction

    function automatic void gen_decimal();
        int n_int;
        int n_dec;
        int n_exp;
        int k;
        n_int = $urandom_range(0, 4);
        n_dec = 0;
        for (k = 0; k < n_int; k++)
            put(dec_digit());
        if ($urandom_range(0, 99) < 50)
        begin
            put(CH_DOT);
            n_dec = $urandom_range(0, 4);
            for (k = 0; k < n_dec; k++)
                put(dec_digit());
        end
        // keep most strings well formed: at least one mantissa digit
        if (n_int == 0 && n_dec == 0 && $urandom_range(0, 99) < 85)
            put(dec_digit());
        if ($urandom_range(0, 99) < 40)
        begin
            put($urandom_range(0, 1) ? CH_E_UP : CH_E_LO);
            case ($urandom_range(0, 2))
                0: put(CH_PLUS);
                1: put(CH_MINUS);
                default: ;
            endcase
            k = $urandom_range(0, 99);
            n_exp = (k < 5) ? 0 : (k < 15) ? $urandom_range(5, 7) : $urandom_range(1, 2);
            for (k = 0; k < n_exp; k++)
                put(dec_digit());
        end
    endfunction

    function automatic void gen_based(input int r);
        int n;
        int k;
        if ((r == 16 || r == 8 || r == 2) && $urandom_range(0, 1))
        begin
            put(CH_ZERO);
            case (r)
                16: put($urandom_range(0, 1) ? CH_X_UP : CH_X_LO);
                8:  put($urandom_range(0, 1) ? CH_O_UP : CH_O_LO);
                default: put($urandom_range(0, 1) ? CH_B_UP : CH_B_LO);
            endcase
        end
        n = ($urandom_range(0, 99) < 10) ? 0 : $urandom_range(1, 5);
        for (k = 0; k < n; k++)
            put(based_digit(r));
    endfunction

    // body of one string, no last mark yet
    function automatic void build_string();
        int sel;
        int gr;
        int k;
        logic [7:0] junk;
        beat_t b;
        sel = $urandom_range(0, 99);
        gr  = (radix_now >= RADIX_MIN && radix_now <= RADIX_MAX) ?
              int'(radix_now) : $urandom_range(2, 36);
        if (sel < 3)
            return;   // empty string
        if (sel < 13)
        begin
            // noise: any byte at all
            for (k = $urandom_range(1, 5); k > 0; k--)
                put(8'($urandom_range(0, 255)));
            return;
        end
        if (radix_now == RADIX_DEC)
            gen_decimal();
        else
            gen_based(gr);
        // broken: one character swapped for a random byte
        if (sel < 23 && text_q.size() != 0)
        begin
            k      = $urandom_range(0, text_q.size() - 1);
            junk   = 8'($urandom_range(0, 255));
            b      = text_q[k];
            b.code = junk;
            text_q[k] = b;
        end
        // a no-character beat anywhere in the string is ignored
        if ($urandom_range(0, 99) < 5)
            text_q.insert($urandom_range(0, text_q.size()),
                          beat(8'($urandom_range(0, 255)), 1'b1, 1'b0));
    endfunction

    // put the last mark on the final character or on an extra empty beat
    function automatic void close_string();
        beat_t b;
        if (text_q.size() == 0 || $urandom_range(0, 99) < 5)
            text_q.push_back(beat(8'($urandom_range(0, 255)), 1'b1, 1'b1));
        else
        begin
            b = text_q.pop_back();
            b.fin = 1'b1;
            text_q.push_back(b);
        end
    endfunction

    // ------------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------------

    // receiver stalls in short bursts, except through the quiet stretch
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if (!no_idle && $urandom_range(0, 99) < 4)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    // compare each accepted class beat with the oldest one due
    always @(posedge clk)
    begin
        logic [1:0] want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            if (due_classes.size() == 0)
            begin
                $display("%0t: num_class beat with nothing due: expected none, got %0d",
                         $time, num_class);
                errors++;
            end
            else
            begin
                want = due_classes.pop_front();
                if (num_class !== want)
                begin
                    $display("%0t: num_class mismatch: expected %0d, got %0d",
                             $time, want, num_class);
                    errors++;
                end
            end
        end
    end

    // cycles since any beat moved on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < WATCHDOG_CYCLES)
            @(posedge clk);
        $display("numeric_string_classifier_test: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------

    initial
    begin
        int         plan [NUM_PHASES];
        int         i;
        int         k;
        int         total;
        int         ph;
        int         r;
        int         quota;
        int         sent;
        logic [7:0] c;
        beat_t      b;

        // radix, text, fill, reps, hole, class
        rows = '{
            '{10, "",        8'h00, 0,   0,  CLS_INVALID},  // empty string
            '{10, "0",       8'h00, 0,   -1, CLS_INTEGER},
            '{10, "9",       8'h00, 0,   -1, CLS_INTEGER},
            '{10, "1.5",     8'h00, 0,   -1, PREDICT},
            '{10, "2.50e1",  8'h00, 0,   -1, PREDICT},
            '{10, "1e-3",    8'h00, 0,   -1, PREDICT},
            '{10, "100E-2",  8'h00, 0,   -1, PREDICT},
            '{10, ".5e+1",   8'h00, 0,   -1, PREDICT},
            '{10, "1e+",     8'h00, 0,   -1, CLS_INVALID},  // sign, no exponent digit
            '{10, ".",       8'h00, 0,   -1, CLS_INVALID},
            '{10, "7e99999", 8'h00, 0,   -1, PREDICT},      // exponent saturates
            '{10, "12",      8'h00, 0,   1,  PREDICT},      // empty beat mid-string
            '{10, "3",       8'h00, 0,   1,  PREDICT},      // last mark on an empty beat
            '{10, "1",       8'h00, 1,   -1, CLS_INVALID},  // lowest byte
            '{10, "1",       8'hFF, 1,   -1, CLS_INVALID},  // highest byte
            '{10, "",        8'h31, 255, -1, PREDICT},      // longest legal string
            '{10, "",        8'h31, 256, -1, CLS_INVALID},  // one character too many
            '{16, "0xFF",    8'h00, 0,   -1, PREDICT},
            '{16, "0X",      8'h00, 0,   -1, CLS_INVALID},  // prefix without digits
            '{8,  "0o17",    8'h00, 0,   -1, PREDICT},
            '{8,  "08",      8'h00, 0,   -1, CLS_INVALID},
            '{2,  "0B101",   8'h00, 0,   -1, PREDICT},
            '{36, "zZ9",     8'h00, 0,   -1, PREDICT},
            '{0,  "1",       8'h00, 0,   -1, CLS_INVALID},  // radix out of range
            '{1,  "1",       8'h00, 0,   -1, CLS_INVALID},
            '{37, "1",       8'h00, 0,   -1, CLS_INVALID},
            '{63, "1",       8'h00, 0,   -1, CLS_INVALID}
        };
        // radix of each random phase, -1 picks one at random
        plan = '{10, 10, 16, 8, 2, 36, 3, 0, 63, -1, 1, 37, 25, 10};

        radix_now = RADIX_DEC;
        clear_string_state();

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (i = 0; i < NUM_ROWS; i++)
        begin
            if (rows[i].radix != int'(radix_now))
                set_radix(6'(rows[i].radix));
            total = rows[i].text.len() + rows[i].reps;
            for (k = 0; k < total; k++)
            begin
                if (k == rows[i].hole)
                    send_beat(beat(8'($urandom_range(0, 255)), 1'b1, 1'b0), PREDICT);
                c = (k < rows[i].text.len()) ? rows[i].text[k] : rows[i].fill;
                send_beat(beat(c, 1'b0, k == total - 1 && rows[i].hole != total),
                          rows[i].cls);
            end
            if (rows[i].hole == total)
                send_beat(beat(8'h00, 1'b1, 1'b1), rows[i].cls);
        end

        // random phases; a phase may stop mid-string, so the next radix
        // takes over part way through that string
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            r = (plan[ph] < 0) ? $urandom_range(2, 36) : plan[ph];
            if (r != int'(radix_now))
                set_radix(6'(r));
            no_idle = (ph == 1);
            // the stretch without idling gets the largest share
            quota   = (ph == 1) ? 60 : (r >= 2 && r <= 36) ? 14 : 5;
            sent    = 0;
            while (sent < quota)
            begin
                text_q.delete();
                build_string();
                if (!(sent + text_q.size() >= quota && text_q.size() != 0 &&
                      $urandom_range(0, 1)))
                    close_string();
                while (text_q.size() != 0)
                begin
                    b = text_q.pop_front();
                    send_beat(b, PREDICT);
                    if (!b.none || b.fin)
                        sent++;
                end
            end
        end
        no_idle = 1'b0;

        // drain, then let anything still in the pipe settle
        in_valid <= 1'b0;
        while (due_classes.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (errors == 0)
            $display("numeric_string_classifier_test: clean");
        else
            $display("numeric_string_classifier_test: errors");
        $finish;
    end

endmodule
`default_nettype wire
